@@ rtl/ale_pkg.sv @@
package ale_pkg;

    // Fixed number of entries in the element store.
    localparam int CAPACITY = 128;
    // Address width of the store and width of the list length.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    // Width used to compare an 8-bit position against the length without overflow.
    localparam int CW = ((LW > 8) ? LW : 8) + 1;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_PRIOR  = 3'd2,
        OP_NEXT   = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_APPEND = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Access of the sequencer to the element store.
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [31:0]   wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } ram_req_t;

    // One finished result.
    typedef struct packed {
        status_t     status;
        logic [31:0] value_out;
        logic [7:0]  found_position;
        logic [7:0]  count;
        logic        is_empty;
    } result_t;

endpackage

@@ rtl/ale_ram.sv @@
module ale_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [ABITS-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/ale_seq.sv @@
module ale_seq
    import ale_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  op_t         in_op,
    input  logic [7:0]  in_pos,
    input  logic [31:0] in_val,
    output ram_req_t    ram,
    input  logic [31:0] rdata,
    input  logic        out_free,
    output logic        res_valid,
    output result_t     res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] len_new_reg, len_new_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] first_reg, first_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] tag_reg, tag_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic          iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [31:0]   prev_reg, prev_next;
    status_t       st_reg, st_next;
    logic [31:0]   vout_reg, vout_next;
    logic [7:0]    fpos_reg, fpos_next;

    logic [CW-1:0] pos_w, len_w;
    logic          pos_ok_rd, pos_ok_ins, full;
    logic [AW-1:0] pm1, lm1;

    assign pos_w      = CW'(in_pos);
    assign len_w      = CW'(len_reg);
    assign pos_ok_rd  = (pos_w != '0) && (pos_w <= len_w);
    assign pos_ok_ins = (pos_w != '0) && (pos_w <= len_w + CW'(1));
    assign full       = (len_reg == LW'(CAPACITY));
    assign pm1        = AW'(pos_w - CW'(1));
    assign lm1        = AW'(len_reg - LW'(1));

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        len_next     = len_reg;
        len_new_next = len_new_reg;
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        wa_next      = wa_reg;
        iss_next     = iss_reg;
        prev_next    = prev_reg;
        st_next      = st_reg;
        vout_next    = vout_reg;
        fpos_next    = fpos_reg;
        ram          = '0;
        res_valid    = 1'b0;
        res          = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next      = in_op;
                    val_next     = in_val;
                    len_new_next = len_reg;
                    st_next      = ST_OK;
                    vout_next    = '0;
                    fpos_next    = '0;
                    state_next   = S_DONE;
                    case (in_op)
                        OP_GET: begin
                            if (!pos_ok_rd) begin
                                st_next = ST_BAD_POS;
                            end else begin
                                cnt_next   = pm1;
                                first_next = pm1;
                                last_next  = pm1;
                                iss_next   = 1'b1;
                                state_next = S_RUN;
                            end
                        end
                        OP_LOCATE, OP_PRIOR, OP_NEXT: begin
                            st_next = ST_NOT_FOUND;
                            if (len_reg != '0) begin
                                cnt_next   = '0;
                                first_next = '0;
                                last_next  = lm1;
                                iss_next   = 1'b1;
                                state_next = S_RUN;
                            end
                        end
                        OP_INSERT: begin
                            if (!pos_ok_ins) begin
                                st_next = ST_BAD_POS;
                            end else if (full) begin
                                st_next = ST_FULL;
                            end else begin
                                len_new_next = len_reg + LW'(1);
                                wa_next      = pm1;
                                if (pos_w == len_w + CW'(1)) begin
                                    state_next = S_WRITE;
                                end else begin
                                    // Shift from the top element down to the position.
                                    cnt_next   = lm1;
                                    first_next = lm1;
                                    last_next  = pm1;
                                    iss_next   = 1'b1;
                                    state_next = S_RUN;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (!pos_ok_rd) begin
                                st_next = ST_BAD_POS;
                            end else begin
                                len_new_next = len_reg - LW'(1);
                                cnt_next     = pm1;
                                first_next   = pm1;
                                last_next    = lm1;
                                iss_next     = 1'b1;
                                state_next   = S_RUN;
                            end
                        end
                        OP_CLEAR: begin
                            len_new_next = '0;
                        end
                        default: begin
                            if (full) begin
                                st_next = ST_FULL;
                            end else begin
                                wa_next      = AW'(len_reg);
                                len_new_next = len_reg + LW'(1);
                                state_next   = S_WRITE;
                            end
                        end
                    endcase
                end
            end

            S_RUN: begin
                // Read stream: one element address per cycle.
                if (iss_reg) begin
                    ram.re    = 1'b1;
                    ram.raddr = cnt_reg;
                    if (cnt_reg == last_reg) begin
                        iss_next = 1'b0;
                    end else if (op_reg == OP_INSERT) begin
                        cnt_next = cnt_reg - AW'(1);
                    end else begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
                // Data of the read issued in the previous cycle.
                if (pend_reg) begin
                    prev_next = rdata;
                    case (op_reg)
                        OP_GET: begin
                            vout_next = rdata;
                        end
                        OP_LOCATE: begin
                            if (rdata == val_reg) begin
                                st_next    = ST_OK;
                                fpos_next  = 8'(LW'(tag_reg) + LW'(1));
                                iss_next   = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        OP_PRIOR: begin
                            if (tag_reg != '0 && rdata == val_reg) begin
                                st_next   = ST_OK;
                                vout_next = prev_reg;
                            end
                        end
                        OP_NEXT: begin
                            if (tag_reg != '0 && prev_reg == val_reg) begin
                                st_next   = ST_OK;
                                vout_next = rdata;
                            end
                        end
                        OP_INSERT: begin
                            ram.we    = 1'b1;
                            ram.waddr = tag_reg + AW'(1);
                            ram.wdata = rdata;
                        end
                        OP_DELETE: begin
                            if (tag_reg == first_reg) begin
                                vout_next = rdata;
                            end else begin
                                ram.we    = 1'b1;
                                ram.waddr = tag_reg - AW'(1);
                                ram.wdata = rdata;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (tag_reg == last_reg) begin
                        iss_next   = 1'b0;
                        state_next = (op_reg == OP_INSERT) ? S_WRITE : S_DONE;
                    end
                end
            end

            S_WRITE: begin
                ram.we     = 1'b1;
                ram.waddr  = wa_reg;
                ram.wdata  = val_reg;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    res_valid          = 1'b1;
                    res.status         = st_reg;
                    res.value_out      = vout_reg;
                    res.found_position = fpos_reg;
                    res.count          = 8'(len_new_reg);
                    res.is_empty       = (len_new_reg == '0);
                    len_next           = len_new_reg;
                    state_next         = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        pend_next = ram.re;
        tag_next  = ram.re ? ram.raddr : tag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            len_new_reg <= '0;
            iss_reg     <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            len_new_reg <= len_new_next;
            iss_reg     <= iss_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        tag_reg   <= tag_next;
        wa_reg    <= wa_next;
        prev_reg  <= prev_next;
        st_reg    <= st_next;
        vout_reg  <= vout_next;
        fpos_reg  <= fpos_next;
    end

endmodule

@@ rtl/array_list_engine_unit.sv @@
// Array list engine: keeps an ordered list of signed 32-bit values (up to
// CAPACITY entries, 128 as built) in a single on-chip memory, plus its
// length. Each input word carries an opcode, a 1-based position and a value,
// and produces exactly one result word, in order. One word is worked on at a
// time, and get, locate, prior, next, insert and delete stream through the
// memory at one element per cycle, limited by its single read port and
// single write port; locate stops at the first match. A finished result
// sits in an output register, so the next word is taken while the previous
// result still waits. The shift of insert and delete never reads and writes
// the same entry in one cycle, so no forwarding is needed. The store's
// contents are not cleared at reset; only entries below the list length are
// ever read.
module array_list_engine_unit
    import ale_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input words. s_tdata fields from bit 0: opcode[2:0], position[10:3],
    // value[42:11]; bits 47:43 are zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // Result words. m_tdata fields from bit 0: status[1:0], value_out[33:2],
    // found_position[41:34], count[49:42], is_empty[50]; bits 55:51 are zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata
);

    ram_req_t    ram;
    logic [31:0] rdata;
    logic        res_valid;
    result_t     res;
    logic        out_free;

    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;

    // The output register can take a new result when it is empty or is being
    // drained in this cycle.
    assign out_free = !out_valid_reg || m_tready;

    ale_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tdata[2:0])),
        .in_pos    (s_tdata[10:3]),
        .in_val    (s_tdata[42:11]),
        .ram       (ram),
        .rdata     (rdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    ale_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (32),
        .ABITS (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (rdata)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_data_reg.is_empty,
                       out_data_reg.count,
                       out_data_reg.found_position,
                       out_data_reg.value_out,
                       out_data_reg.status};

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import ale_pkg::*;

    // Cycles without any word moving on either side before the run is abandoned.
    localparam int IDLE_LIMIT  = 5000;
    // Rough number of input words for the whole run.
    localparam int ITEM_TARGET = 1100;
    // Index of the look-ahead copy of the list used to shape stimulus, and of
    // the copy that follows the words actually accepted by the block.
    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    typedef struct packed {
        op_t         op;
        logic [7:0]  position;
        logic [31:0] value;
    } list_item_t;

    // Flavor of a batch of random words: mostly growing, mostly shrinking, or even.
    typedef enum int {GROW = 0, SHRINK = 1, MIXED = 2} batch_kind_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    // Two independent copies of the list: element store and length.
    logic [31:0] list_store [2][CAPACITY];
    int unsigned list_len [2] = '{0, 0};

    // Chance, in percent, of each opcode (get .. append) for each batch flavor.
    int op_weight [3][8] = '{'{6, 4, 4, 4, 35, 2, 0, 45},
                             '{12, 10, 8, 8, 7, 40, 1, 14},
                             '{13, 13, 12, 12, 16, 16, 2, 16}};

    list_item_t  pending_words [$];
    result_t     pending_results [$];
    list_item_t  word_on_bus;
    bit          word_taken     = 1'b0;
    bit          send_calm      = 1'b0;
    bit          recv_calm      = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned recv_stall     = 0;
    int unsigned words_queued   = 0;
    int unsigned words_accepted = 0;
    int unsigned idle_cycles    = 0;
    int unsigned mismatch_count = 0;

    array_list_engine_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one word to the chosen copy of the list and returns its result.
    function automatic result_t list_apply(int unsigned copy, list_item_t it);
        result_t     res;
        int unsigned len;
        int unsigned pos;
        bit          hit;
        res = '0;
        res.status = ST_OK;
        len = list_len[copy];
        pos = it.position;
        hit = 1'b0;
        case (it.op)
            OP_GET: begin
                if (pos < 1 || pos > len) res.status = ST_BAD_POS;
                else res.value_out = list_store[copy][pos-1];
            end
            OP_LOCATE: begin
                for (int i = 0; i < len && !hit; i++) begin
                    if (list_store[copy][i] == it.value) begin
                        res.found_position = 8'(i + 1);
                        hit = 1'b1;
                    end
                end
                if (!hit) res.status = ST_NOT_FOUND;
            end
            OP_PRIOR: begin
                // The last match wins; a match on the first element has no predecessor.
                for (int i = 1; i < len; i++) begin
                    if (list_store[copy][i] == it.value) begin
                        res.value_out = list_store[copy][i-1];
                        hit = 1'b1;
                    end
                end
                if (!hit) res.status = ST_NOT_FOUND;
            end
            OP_NEXT: begin
                for (int i = 0; i + 1 < len; i++) begin
                    if (list_store[copy][i] == it.value) begin
                        res.value_out = list_store[copy][i+1];
                        hit = 1'b1;
                    end
                end
                if (!hit) res.status = ST_NOT_FOUND;
            end
            OP_INSERT: begin
                // The position is judged before the store is found full.
                if (pos < 1 || pos > len + 1) begin
                    res.status = ST_BAD_POS;
                end else if (len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = len; i > pos - 1; i--)
                        list_store[copy][i] = list_store[copy][i-1];
                    list_store[copy][pos-1] = it.value;
                    len++;
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > len) begin
                    res.status = ST_BAD_POS;
                end else begin
                    res.value_out = list_store[copy][pos-1];
                    for (int i = pos - 1; i + 1 < len; i++)
                        list_store[copy][i] = list_store[copy][i+1];
                    len--;
                end
            end
            OP_CLEAR: len = 0;
            default: begin
                if (len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_store[copy][len] = it.value;
                    len++;
                end
            end
        endcase
        list_len[copy] = len;
        res.count = 8'(len);
        res.is_empty = (len == 0);
        return res;
    endfunction

    function automatic list_item_t make_word(op_t op, int unsigned pos, logic [31:0] value);
        list_item_t it;
        it.op = op;
        it.position = 8'(pos);
        it.value = value;
        return it;
    endfunction

    // Random word shaped by the look-ahead copy: positions mostly legal,
    // searches mostly for values held in the list, stored values often repeated.
    function automatic list_item_t random_word(batch_kind_t kind);
        list_item_t  it;
        int unsigned len;
        int unsigned r;
        int unsigned hi;
        int unsigned acc;
        len = list_len[PLAN];
        r = $urandom_range(0, 99);
        acc = 0;
        it.op = OP_GET;
        for (int c = 0; c < 8; c++) begin
            if (op_weight[kind][c] > 0 && r >= acc) it.op = op_t'(c);
            acc += op_weight[kind][c];
        end

        hi = (it.op == OP_INSERT) ? len + 1 : len;
        r = $urandom_range(0, 99);
        if (r < 12) it.position = 8'($urandom_range(0, 129));
        else if (r < 15) it.position = 8'd0;
        else if (r < 18) it.position = 8'(hi + 1);
        else if (hi == 0) it.position = 8'd1;
        else if (r < 24) it.position = 8'd1;
        else if (r < 30) it.position = 8'(hi);
        else it.position = 8'($urandom_range(1, hi));

        r = $urandom_range(0, 99);
        if ((it.op == OP_LOCATE || it.op == OP_PRIOR || it.op == OP_NEXT) && len > 0 && r < 70)
            it.value = list_store[PLAN][$urandom_range(0, len - 1)];
        else if (r < 35)
            it.value = 32'($urandom_range(0, 7)) - 32'd4;
        else if (r < 45)
            case ($urandom_range(0, 3))
                0: it.value = 32'h8000_0000;
                1: it.value = 32'h7fff_ffff;
                2: it.value = 32'h0000_0000;
                default: it.value = 32'hffff_ffff;
            endcase
        else
            it.value = $urandom;
        return it;
    endfunction

    // Mostly short gaps, now and then a long one; none at all in a calm stretch.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_word(list_item_t it);
        void'(list_apply(PLAN, it));
        pending_words.push_back(it);
        words_queued++;
    endtask

    // Holds the stimulus until every queued word is in and every result is out.
    task automatic wait_for_drain();
        @(negedge aclk);
        while (words_accepted != words_queued || pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Sender: presents the next pending word once the previous one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            word_taken = 1'b0;
        end else if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                word_on_bus = pending_words.pop_front();
                s_tdata <= {5'd0, word_on_bus.value, word_on_bus.position, word_on_bus.op};
                s_tvalid <= 1'b1;
                send_gap = pick_gap(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure on the result side.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            recv_stall = pick_gap(recv_calm);
        end
    end

    // Checks each result word against the oldest prediction, then predicts
    // the result of a word accepted at this edge.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word arrived with no prediction pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                compare_field("value_out", want.value_out, m_tdata[33:2]);
                compare_field("found_position", 32'(want.found_position), 32'(m_tdata[41:34]));
                compare_field("count", 32'(want.count), 32'(m_tdata[49:42]));
                compare_field("is_empty", 32'(want.is_empty), 32'(m_tdata[50]));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            pending_results.push_back(list_apply(CHECK, word_on_bus));
            words_accepted++;
            word_taken = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        batch_kind_t kind;
        int unsigned batch_len;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words: empty-list errors, extreme values, repeated values for
        // prior and next, inserts at front, middle and end, and clear.
        queue_word(make_word(OP_GET,    1,   32'h0000_0001));
        queue_word(make_word(OP_DELETE, 1,   32'h0000_0002));
        queue_word(make_word(OP_LOCATE, 0,   32'h0000_0000));
        queue_word(make_word(OP_PRIOR,  0,   32'h0000_0000));
        queue_word(make_word(OP_NEXT,   0,   32'h0000_0000));
        queue_word(make_word(OP_INSERT, 0,   32'h1111_1111));
        queue_word(make_word(OP_INSERT, 2,   32'h2222_2222));
        queue_word(make_word(OP_INSERT, 1,   32'h8000_0000));
        queue_word(make_word(OP_APPEND, 0,   32'h7fff_ffff));
        queue_word(make_word(OP_APPEND, 129, 32'hffff_ffff));
        queue_word(make_word(OP_INSERT, 2,   32'h0000_0000));
        queue_word(make_word(OP_APPEND, 255, 32'h7fff_ffff));
        queue_word(make_word(OP_GET,    5,   32'hffff_ffff));
        queue_word(make_word(OP_GET,    6,   32'h0000_0000));
        queue_word(make_word(OP_GET,    0,   32'h0000_0000));
        queue_word(make_word(OP_LOCATE, 3,   32'h7fff_ffff));
        queue_word(make_word(OP_PRIOR,  1,   32'h7fff_ffff));
        queue_word(make_word(OP_NEXT,   1,   32'h7fff_ffff));
        queue_word(make_word(OP_PRIOR,  0,   32'h8000_0000));
        queue_word(make_word(OP_INSERT, 6,   32'h1234_5678));
        queue_word(make_word(OP_INSERT, 129, 32'h5555_5555));
        queue_word(make_word(OP_DELETE, 6,   32'h0000_0000));
        queue_word(make_word(OP_DELETE, 1,   32'h0000_0000));
        queue_word(make_word(OP_CLEAR,  128, 32'haaaa_aaaa));
        queue_word(make_word(OP_GET,    1,   32'h0000_0000));

        // Fill the store to capacity, then keep pushing so the full status shows.
        while (list_len[PLAN] < CAPACITY)
            queue_word(random_word(GROW));
        repeat (10) queue_word(random_word(GROW));
        wait_for_drain();

        while (words_queued < ITEM_TARGET) begin
            kind = batch_kind_t'($urandom_range(0, 2));
            batch_len = $urandom_range(40, 160);
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            repeat (batch_len) queue_word(random_word(kind));
            if ($urandom_range(0, 2) == 0) wait_for_drain();
        end

        wait_for_drain();
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
